@@ hdl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescape block.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape; no dependencies.
`default_nettype none

package jsu_pkg;

  // Verdict codes carried in the status field.
  localparam logic [2:0] ST_BUSY  = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_ESC   = 3'd3;
  localparam logic [2:0] ST_HEX   = 3'd4;
  localparam logic [2:0] ST_SPARE = 3'd5;
  localparam logic [2:0] ST_CLOSE = 3'd6;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_BODY  = 6'b000010,
    PH_ESC   = 6'b000100,
    PH_HEX   = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  // Everything one text byte produces: up to three decoded bytes and the verdict.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic [2:0]      status;
  } run_t;

endpackage

`default_nettype wire

@@ hdl/jsu_front.sv @@
// Front end: accepts text bytes, tracks the parser state and decodes escapes.
// Depends on jsu_pkg; produces one run_t entry per accepted byte.
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_text,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jsu_pkg::run_t      out_run,
  output jsu_pkg::phase_t    cur_phase
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  jsu_pkg::phase_t phase, phase_next;
  logic [1:0]      hex_count, hex_count_next;
  logic [15:0]     code_point, code_point_next;
  logic [2:0]      error_code, error_code_next;

  logic            hex_ok;
  logic [3:0]      hex_val;
  logic [15:0]     cp_shift;
  logic            close;
  logic            accept;
  jsu_pkg::run_t   run;

  // Hex digit of either case; hex_ok low for anything else.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      hex_val = 4'(text_byte - 8'h30);
    end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
      hex_val = 4'(text_byte - 8'h57);
    end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
      hex_val = 4'(text_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_shift = {code_point[11:0], hex_val};

  always_comb begin
    phase_next      = phase;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    error_code_next = error_code;
    run             = '0;
    close           = 1'b0;
    if (text_byte == CH_NUL) begin
      close = 1'b1;
    end else begin
      case (phase)
        jsu_pkg::PH_LEAD: begin
          if (text_byte == CH_QUOTE) begin
            phase_next = jsu_pkg::PH_BODY;
          end else if (text_byte > CH_SPACE) begin
            error_code_next = jsu_pkg::ST_START;
            phase_next      = jsu_pkg::PH_DONE;
          end
        end
        jsu_pkg::PH_BODY: begin
          if (text_byte == CH_QUOTE) begin
            phase_next = jsu_pkg::PH_TRAIL;
          end else if (text_byte == CH_BSL) begin
            phase_next = jsu_pkg::PH_ESC;
          end else begin
            run.bytes[0] = text_byte;
            run.count    = 2'd1;
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_next = jsu_pkg::PH_BODY;
          run.count  = 2'd1;
          case (text_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: run.bytes[0] = text_byte;
            CH_B: run.bytes[0] = 8'h08;
            CH_F: run.bytes[0] = 8'h0C;
            CH_N: run.bytes[0] = 8'h0A;
            CH_R: run.bytes[0] = 8'h0D;
            CH_T: run.bytes[0] = 8'h09;
            CH_U: begin
              run.count       = 2'd0;
              phase_next      = jsu_pkg::PH_HEX;
              hex_count_next  = 2'd0;
              code_point_next = 16'd0;
            end
            default: begin
              run.count       = 2'd0;
              error_code_next = jsu_pkg::ST_ESC;
              phase_next      = jsu_pkg::PH_DONE;
            end
          endcase
        end
        jsu_pkg::PH_HEX: begin
          if (!hex_ok) begin
            error_code_next = jsu_pkg::ST_HEX;
            phase_next      = jsu_pkg::PH_DONE;
          end else begin
            code_point_next = cp_shift;
            if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
            end else begin
              hex_count_next = 2'd0;
              phase_next     = jsu_pkg::PH_BODY;
              // UTF-8 encoding of a basic-plane code point.
              if (cp_shift[15:7] == 9'd0) begin
                run.bytes[0] = cp_shift[7:0];
                run.count    = 2'd1;
              end else if (cp_shift[15:11] == 5'd0) begin
                run.bytes[0] = {3'b110, cp_shift[10:6]};
                run.bytes[1] = {2'b10, cp_shift[5:0]};
                run.count    = 2'd2;
              end else begin
                run.bytes[0] = {4'b1110, cp_shift[15:12]};
                run.bytes[1] = {2'b10, cp_shift[11:6]};
                run.bytes[2] = {2'b10, cp_shift[5:0]};
                run.count    = 2'd3;
              end
            end
          end
        end
        jsu_pkg::PH_TRAIL: begin
          if (text_byte > CH_SPACE) begin
            error_code_next = jsu_pkg::ST_SPARE;
            phase_next      = jsu_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
      close = end_of_text;
    end
    // Closing the text settles the verdict from the phase reached.
    if (close) begin
      if (error_code_next == jsu_pkg::ST_BUSY) begin
        case (phase_next)
          jsu_pkg::PH_TRAIL: error_code_next = jsu_pkg::ST_OK;
          jsu_pkg::PH_LEAD:  error_code_next = jsu_pkg::ST_START;
          jsu_pkg::PH_ESC:   error_code_next = jsu_pkg::ST_ESC;
          jsu_pkg::PH_HEX:   error_code_next = jsu_pkg::ST_HEX;
          default:           error_code_next = jsu_pkg::ST_CLOSE;
        endcase
      end
      phase_next = jsu_pkg::PH_DONE;
    end
    run.status = error_code_next;
  end

  assign accept    = in_valid && out_ready;
  assign in_ready  = out_ready;
  assign out_valid = in_valid;
  assign out_run   = run;
  assign cur_phase = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsu_pkg::PH_LEAD;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
      error_code <= jsu_pkg::ST_BUSY;
    end else if (accept) begin
      if (end_of_text) begin
        phase      <= jsu_pkg::PH_LEAD;
        hex_count  <= 2'd0;
        code_point <= 16'd0;
        error_code <= jsu_pkg::ST_BUSY;
      end else begin
        phase      <= phase_next;
        hex_count  <= hex_count_next;
        code_point <= code_point_next;
        error_code <= error_code_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/jsu_queue.sv @@
// Small register queue of decoded runs between the front and back ends.
// Depends on jsu_pkg for the run_t entry type.
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire jsu_pkg::run_t wr_run,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output jsu_pkg::run_t      rd_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jsu_pkg::run_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] level;
  logic             push, pop;

  assign wr_ready = (level != FULL_CNT);
  assign rd_valid = (level != '0);
  assign rd_run   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + CNT_W'(1);
      end else if (pop && !push) begin
        level <= level - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/jsu_back.sv @@
// Back end: splits each queued run into result transactions in an output register.
// Depends on jsu_pkg for the run_t entry type and status codes.
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          run_valid,
  output logic               run_ready,
  input  wire jsu_pkg::run_t run,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic [7:0]         res_byte,
  output logic               res_has_byte,
  output logic [2:0]         res_status,
  output logic               res_last
);

  logic [1:0] idx;
  logic [1:0] total;
  logic       load;
  logic       at_end;

  // A run with no bytes still yields one result carrying the status.
  assign total     = (run.count == 2'd0) ? 2'd1 : run.count;
  assign at_end    = (idx == total - 2'd1);
  assign load      = run_valid && (!res_valid || res_ready);
  assign run_ready = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_byte     <= (run.count == 2'd0) ? 8'd0 : run.bytes[idx];
      res_has_byte <= (run.count != 2'd0);
      res_status   <= run.status;
      res_last     <= at_end;
    end
  end

endmodule

`default_nettype wire

@@ hdl/json_string_unescape.sv @@
// Top level of the JSON string unescape block: front end, run queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Usage. Text bytes arrive on the slave stream, one byte per transaction in
// s_axis_tdata, with s_axis_tlast on the final byte of a text. Each accepted
// byte produces one to three result transactions on the master stream: one
// per decoded byte, or a single one with no byte (tuser low, data zero) when
// the input byte decodes to nothing. m_axis_tlast marks the final result of
// each input byte, and every result carries the verdict so far as status.
// The run of an accepted byte is written into the run queue, and its first
// result is then loaded from the queue into the output register once that
// register is free. Throughput: one input byte per cycle while each byte
// yields a single result and the receiver does not stall; a \u escape that
// expands to two or three UTF-8 bytes occupies the output register for one
// result per byte, and the run queue (QUEUE_DEPTH entries) absorbs the
// difference until it fills.
// Reset (rst, synchronous) returns the parser to the leading-blank phase and
// empties the queue and output register. If the receiver stalls, the output
// register holds its transaction, the queue fills, and s_axis_tready then
// drops until space frees up; nothing is lost or repeated.
`default_nettype none

module json_string_unescape #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [10:8] status, rest zero
  output logic             m_axis_tuser,   // has_byte
  output logic             m_axis_tlast    // last_of_run
);

  jsu_pkg::run_t   front_run, queue_run;
  jsu_pkg::phase_t front_phase;
  logic            front_valid, front_ready;
  logic            queue_valid, queue_ready;
  logic [7:0]      res_byte;
  logic [2:0]      res_status;

  // Front end: parser state and escape decoding, one byte per cycle while the run queue has space.
  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .text_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_run     (front_run),
    .cur_phase   (front_phase)
  );

  // Decouples the parser from output stalls and from multi-byte expansions.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_run   (front_run),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_run   (queue_run)
  );

  // Back end: emits the runs byte by byte through the output register.
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .run_valid    (queue_valid),
    .run_ready    (queue_ready),
    .run          (queue_run),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res_byte     (res_byte),
    .res_has_byte (m_axis_tuser),
    .res_status   (res_status),
    .res_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res_status, res_byte};

  // A result with no byte is always the only, and thus final, one of its run.
  a_empty_result_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("empty result not marked last or carries data");

  // The end of a text always brings the parser back to the leading-blank phase.
  a_text_end_resets: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> front_phase == jsu_pkg::PH_LEAD)
    else $error("parser not restarted after end of text");

  // Once the parser has given up, the verdict it holds is a real one.
  a_done_has_verdict: assert property (@(posedge clk) disable iff (rst)
    front_phase == jsu_pkg::PH_DONE && s_axis_tvalid && s_axis_tready
      |-> front_run.status != jsu_pkg::ST_BUSY)
    else $error("finished parser reports busy");

endmodule

`default_nettype wire
